// ===== hdl/sjfd_pkg.sv =====
// Shared types and default sizes for the shortest-job-first dispatcher.
// No dependencies; used by sjfd_heap and the top level.
package sjfd_pkg;

  localparam int unsigned HeapDepthDef = 64;
  localparam int unsigned IdBitsDef    = 16;
  localparam int unsigned BurstBitsDef = 16;
  localparam int unsigned TimeBits     = 32;

  // One operation request from the dispatcher to the heap sequencer.
  typedef struct packed {
    logic push;
    logic pop;
  } heap_req_t;

endpackage

// ===== hdl/shortest_job_first_dispatcher.sv =====
// Shortest-job-first dispatcher top level: time keeping, run state, command
// handshake and result strobe. Uses sjfd_pkg and sjfd_heap.
//
//   channel  | signals                                          | direction
//   command  | start_i, busy_o, cmd_i, job_id_i, burst_time_i   | in
//   result   | valid_o, dispatched_o, dispatched_id_o,          | out
//            | dropped_o, busy_res_o                            |
//
// A command transfers on start_i high with busy_o low; its result shows on
// valid_o for one cycle. A dropped arrival or a tick without dispatch answers
// the cycle after the transfer. An arrival sifts up and a dispatching tick sifts
// down one heap level at a time over the single heap RAM read port; busy_o stays
// high until the heap sequencer is done.
// Reset clears the heap count, time, end time and run state. The receiver cannot stall.
module shortest_job_first_dispatcher #(
  parameter int unsigned HEAP_DEPTH = sjfd_pkg::HeapDepthDef,
  parameter int unsigned ID_BITS    = sjfd_pkg::IdBitsDef,
  parameter int unsigned BURST_BITS = sjfd_pkg::BurstBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  cmd_i,
  input  logic [ID_BITS-1:0]    job_id_i,
  input  logic [BURST_BITS-1:0] burst_time_i,
  output logic                  valid_o,
  output logic                  dispatched_o,
  output logic [ID_BITS-1:0]    dispatched_id_o,
  output logic                  dropped_o,
  output logic                  busy_res_o
);

  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned TB = sjfd_pkg::TimeBits;

  localparam logic CmdTick = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WAIT = 2'b10
  } top_state_e;

  top_state_e state_q, state_d;
  logic [TB-1:0] now_q, now_d;
  logic [TB-1:0] end_q, end_d;
  logic          running_q, running_d;
  logic          pend_pop_q, pend_pop_d;
  logic          valid_q, valid_d;

  logic               disp_q, disp_d;
  logic [ID_BITS-1:0] disp_id_q, disp_id_d;
  logic               drop_q, drop_d;
  logic               busy_res_q, busy_res_d;

  sjfd_pkg::heap_req_t   req;
  logic [CW-1:0]         count;
  logic                  heap_done;
  logic [ID_BITS-1:0]    top_id;
  logic [BURST_BITS-1:0] top_burst;

  logic          accept;
  logic          full;
  logic [TB-1:0] now_inc;
  logic          still_running;
  logic          do_pop;

  sjfd_heap #(
    .DEPTH      (HEAP_DEPTH),
    .ID_BITS    (ID_BITS),
    .BURST_BITS (BURST_BITS)
  ) u_heap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .id_i        (job_id_i),
    .burst_i     (burst_time_i),
    .count_o     (count),
    .done_o      (heap_done),
    .top_id_o    (top_id),
    .top_burst_o (top_burst)
  );

  assign busy_o        = (state_q == S_WAIT);
  assign accept        = start_i && !busy_o;
  assign full          = (count >= CW'(HEAP_DEPTH));
  assign now_inc       = now_q + 1'b1;
  // end check happens before dispatch, on the advanced time
  assign still_running = running_q && (end_q != now_inc);
  assign do_pop        = !still_running && (count != '0);

  always_comb begin
    state_d    = state_q;
    now_d      = now_q;
    end_d      = end_q;
    running_d  = running_q;
    pend_pop_d = pend_pop_q;
    valid_d    = 1'b0;
    disp_d     = disp_q;
    disp_id_d  = disp_id_q;
    drop_d     = drop_q;
    busy_res_d = busy_res_q;
    req        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cmd_i == CmdTick) begin
            now_d     = now_inc;
            running_d = still_running;
            if (do_pop) begin
              req.pop    = 1'b1;
              pend_pop_d = 1'b1;
              state_d    = S_WAIT;
            end else begin
              valid_d    = 1'b1;
              disp_d     = 1'b0;
              disp_id_d  = '0;
              drop_d     = 1'b0;
              busy_res_d = still_running;
            end
          end else if (full) begin
            valid_d    = 1'b1;
            disp_d     = 1'b0;
            disp_id_d  = '0;
            drop_d     = 1'b1;
            busy_res_d = running_q;
          end else begin
            req.push   = 1'b1;
            pend_pop_d = 1'b0;
            state_d    = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        if (heap_done) begin
          valid_d = 1'b1;
          drop_d  = 1'b0;
          state_d = S_IDLE;
          if (pend_pop_q) begin
            end_d      = now_q + TB'(top_burst);
            running_d  = 1'b1;
            disp_d     = 1'b1;
            disp_id_d  = top_id;
            busy_res_d = 1'b1;
          end else begin
            disp_d     = 1'b0;
            disp_id_d  = '0;
            busy_res_d = running_q;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      now_q      <= '0;
      end_q      <= '0;
      running_q  <= 1'b0;
      pend_pop_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      now_q      <= now_d;
      end_q      <= end_d;
      running_q  <= running_d;
      pend_pop_q <= pend_pop_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    disp_q     <= disp_d;
    disp_id_q  <= disp_id_d;
    drop_q     <= drop_d;
    busy_res_q <= busy_res_d;
  end

  assign valid_o         = valid_q;
  assign dispatched_o    = disp_q;
  assign dispatched_id_o = disp_id_q;
  assign dropped_o       = drop_q;
  assign busy_res_o      = busy_res_q;

endmodule

// ===== hdl/sjfd_ram.sv =====
// Heap storage: one write port, one read port, registered read data.
// No dependencies.
module sjfd_ram #(
  parameter int unsigned AW = 6,
  parameter int unsigned DW = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sjfd_heap.sv =====
// Binary min-heap on burst length: sequencer for sift-up and sift-down over
// one RAM port pair and one shared greater-than comparator. Uses sjfd_pkg, sjfd_ram.
module sjfd_heap #(
  parameter int unsigned DEPTH      = sjfd_pkg::HeapDepthDef,
  parameter int unsigned ID_BITS    = sjfd_pkg::IdBitsDef,
  parameter int unsigned BURST_BITS = sjfd_pkg::BurstBitsDef,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sjfd_pkg::heap_req_t   req_i,
  input  logic [ID_BITS-1:0]    id_i,
  input  logic [BURST_BITS-1:0] burst_i,
  output logic [CW-1:0]         count_o,
  output logic                  done_o,
  output logic [ID_BITS-1:0]    top_id_o,
  output logic [BURST_BITS-1:0] top_burst_o
);

  localparam int unsigned DW = ID_BITS + BURST_BITS;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_PUSH_RD  = 10'b0000000010,
    S_PUSH_CMP = 10'b0000000100,
    S_POP_TOP  = 10'b0000001000,
    S_POP_LAST = 10'b0000010000,
    S_POP_GET  = 10'b0000100000,
    S_DN_CHK   = 10'b0001000000,
    S_DN_LEFT  = 10'b0010000000,
    S_DN_RIGHT = 10'b0100000000,
    S_DN_CMP   = 10'b1000000000
  } heap_state_e;

  heap_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] cpos_q, cpos_d;
  logic [DW-1:0] new_q, new_d;
  logic [DW-1:0] top_q, top_d;
  logic [DW-1:0] last_q, last_d;
  logic [DW-1:0] child_q, child_d;

  logic          we;
  logic [CW-1:0] wpos;
  logic [DW-1:0] wdata;
  logic [CW:0]   rpos;
  logic [CW-1:0] wpos_m1;
  logic [CW:0]   rpos_m1;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [DW-1:0] rdata;

  logic [BURST_BITS-1:0] gt_a, gt_b;
  logic                  gt;
  logic [CW:0]           left_pos;
  logic [CW:0]           count_ext;

  assign left_pos  = {pos_q, 1'b0};
  assign count_ext = {1'b0, count_q};

  // Heap slots are 1-based; RAM addresses are slot - 1.
  assign wpos_m1 = wpos - 1'b1;
  assign rpos_m1 = rpos - 1'b1;
  assign waddr   = wpos_m1[AW-1:0];
  assign raddr   = rpos_m1[AW-1:0];

  sjfd_ram #(
    .AW (AW),
    .DW (DW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Shared comparator operands
  always_comb begin
    gt_a = '0;
    gt_b = '0;
    unique case (state_q)
      S_PUSH_CMP: begin
        gt_a = rdata[BURST_BITS-1:0];
        gt_b = new_q[BURST_BITS-1:0];
      end
      S_DN_RIGHT: begin
        gt_a = child_q[BURST_BITS-1:0];
        gt_b = rdata[BURST_BITS-1:0];
      end
      S_DN_CMP: begin
        gt_a = last_q[BURST_BITS-1:0];
        gt_b = child_q[BURST_BITS-1:0];
      end
      default: begin
        gt_a = '0;
        gt_b = '0;
      end
    endcase
  end

  assign gt = gt_a > gt_b;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    pos_d   = pos_q;
    cpos_d  = cpos_q;
    new_d   = new_q;
    top_d   = top_q;
    last_d  = last_q;
    child_d = child_q;
    we      = 1'b0;
    wpos    = pos_q;
    wdata   = new_q;
    rpos    = {1'b0, pos_q};
    done_o  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.push) begin
          count_d = count_q + 1'b1;
          pos_d   = count_q + 1'b1;
          new_d   = {id_i, burst_i};
          state_d = S_PUSH_RD;
        end else if (req_i.pop) begin
          state_d = S_POP_TOP;
        end
      end
      S_PUSH_RD: begin
        if (pos_q > CW'(1)) begin
          rpos    = {2'b00, pos_q[CW-1:1]};
          state_d = S_PUSH_CMP;
        end else begin
          we      = 1'b1;
          wdata   = new_q;
          done_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_PUSH_CMP: begin
        we = 1'b1;
        if (gt) begin
          // parent moves down into the hole
          wdata   = rdata;
          pos_d   = {1'b0, pos_q[CW-1:1]};
          state_d = S_PUSH_RD;
        end else begin
          wdata   = new_q;
          done_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_POP_TOP: begin
        rpos    = (CW+1)'(1);
        state_d = S_POP_LAST;
      end
      S_POP_LAST: begin
        top_d   = rdata;
        rpos    = count_ext;
        count_d = count_q - 1'b1;
        state_d = S_POP_GET;
      end
      S_POP_GET: begin
        last_d  = rdata;
        pos_d   = CW'(1);
        state_d = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (left_pos <= count_ext) begin
          rpos    = left_pos;
          state_d = S_DN_LEFT;
        end else begin
          we      = 1'b1;
          wdata   = last_q;
          done_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DN_LEFT: begin
        child_d = rdata;
        cpos_d  = left_pos[CW-1:0];
        if (left_pos != count_ext) begin
          rpos    = {pos_q, 1'b1};
          state_d = S_DN_RIGHT;
        end else begin
          state_d = S_DN_CMP;
        end
      end
      S_DN_RIGHT: begin
        // right child wins only when strictly smaller
        if (gt) begin
          child_d = rdata;
          cpos_d  = cpos_q | CW'(1);
        end
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (gt) begin
          wdata   = child_q;
          pos_d   = cpos_q;
          state_d = S_DN_CHK;
        end else begin
          wdata   = last_q;
          done_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    cpos_q  <= cpos_d;
    new_q   <= new_d;
    top_q   <= top_d;
    last_q  <= last_d;
    child_q <= child_d;
  end

  assign count_o     = count_q;
  assign top_id_o    = top_q[DW-1:BURST_BITS];
  assign top_burst_o = top_q[BURST_BITS-1:0];

endmodule
